[rtl/core/fpd_pkg.sv]
// shared constants, prime table and control types for the factorial power divisibility block
package fpd_pkg;

   // field and counter widths
   localparam int VALUE_W     = 10;
   localparam int EXP_W       = 4;
   localparam int PRIME_COUNT = 172;
   localparam int IDX_W       = $clog2(PRIME_COUNT);

   // answer when no prime of the base bounds the power
   localparam logic [VALUE_W-1:0] NO_BOUND = '1;

   // every prime that fits the field, ascending
   localparam logic [VALUE_W-1:0] PRIME_ROM [PRIME_COUNT] = '{
      10'd2,   10'd3,   10'd5,   10'd7,   10'd11,  10'd13,  10'd17,  10'd19,
      10'd23,  10'd29,  10'd31,  10'd37,  10'd41,  10'd43,  10'd47,  10'd53,
      10'd59,  10'd61,  10'd67,  10'd71,  10'd73,  10'd79,  10'd83,  10'd89,
      10'd97,  10'd101, 10'd103, 10'd107, 10'd109, 10'd113, 10'd127, 10'd131,
      10'd137, 10'd139, 10'd149, 10'd151, 10'd157, 10'd163, 10'd167, 10'd173,
      10'd179, 10'd181, 10'd191, 10'd193, 10'd197, 10'd199, 10'd211, 10'd223,
      10'd227, 10'd229, 10'd233, 10'd239, 10'd241, 10'd251, 10'd257, 10'd263,
      10'd269, 10'd271, 10'd277, 10'd281, 10'd283, 10'd293, 10'd307, 10'd311,
      10'd313, 10'd317, 10'd331, 10'd337, 10'd347, 10'd349, 10'd353, 10'd359,
      10'd367, 10'd373, 10'd379, 10'd383, 10'd389, 10'd397, 10'd401, 10'd409,
      10'd419, 10'd421, 10'd431, 10'd433, 10'd439, 10'd443, 10'd449, 10'd457,
      10'd461, 10'd463, 10'd467, 10'd479, 10'd487, 10'd491, 10'd499, 10'd503,
      10'd509, 10'd521, 10'd523, 10'd541, 10'd547, 10'd557, 10'd563, 10'd569,
      10'd571, 10'd577, 10'd587, 10'd593, 10'd599, 10'd601, 10'd607, 10'd613,
      10'd617, 10'd619, 10'd631, 10'd641, 10'd643, 10'd647, 10'd653, 10'd659,
      10'd661, 10'd673, 10'd677, 10'd683, 10'd691, 10'd701, 10'd709, 10'd719,
      10'd727, 10'd733, 10'd739, 10'd743, 10'd751, 10'd757, 10'd761, 10'd769,
      10'd773, 10'd787, 10'd797, 10'd809, 10'd811, 10'd821, 10'd823, 10'd827,
      10'd829, 10'd839, 10'd853, 10'd857, 10'd859, 10'd863, 10'd877, 10'd881,
      10'd883, 10'd887, 10'd907, 10'd911, 10'd919, 10'd929, 10'd937, 10'd941,
      10'd947, 10'd953, 10'd967, 10'd971, 10'd977, 10'd983, 10'd991, 10'd997,
      10'd1009, 10'd1013, 10'd1019, 10'd1021
   };

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;      // capture a new transaction
      logic pick;      // choose the next prime and divide the base by it
      logic strip;     // base divided evenly: keep quotient, count exponent
      logic skip;      // prime does not divide the base: advance
      logic leg_init;  // start the factorial exponent sum with n / p
      logic leg_step;  // add quotient, divide again or divide sum by exponent
      logic fold;      // fold sum / exponent into the running minimum
   } fpd_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic a_done;     // remaining base is one or zero
      logic div_done;   // divider result ready this cycle
      logic rem_zero;   // divider remainder is zero
      logic e_zero;     // no power of the current prime found
      logic quot_zero;  // divider quotient is zero
   } fpd_status_type;

endpackage

[rtl/core/fpd_divider.sv]
// iterative restoring divider, one quotient bit per cycle
module fpd_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [fpd_pkg::VALUE_W-1:0]  dividend,
   input  logic [fpd_pkg::VALUE_W-1:0]  divisor,
   output logic                         done,
   output logic [fpd_pkg::VALUE_W-1:0]  quotient,
   output logic [fpd_pkg::VALUE_W-1:0]  remainder
);
   import fpd_pkg::*;

   localparam int CNT_W = $clog2(VALUE_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(VALUE_W - 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [VALUE_W-1:0]  quo_ff, quo_in;
   logic [VALUE_W-1:0]  rem_ff, rem_in;
   logic [VALUE_W-1:0]  dsr_ff, dsr_in;
   logic [VALUE_W:0]    shifted;
   logic [VALUE_W:0]    diff;
   logic                fits;

   // one trial subtraction per cycle
   always_comb begin
      shifted = {rem_ff, quo_ff[VALUE_W-1]};
      diff    = shifted - {1'b0, dsr_ff};
      fits    = shifted >= {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[VALUE_W-2:0], fits};
         rem_in = fits ? diff[VALUE_W-1:0] : shifted[VALUE_W-1:0];
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // operands and partial results
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

[rtl/core/fpd_datapath.sv]
// datapath: base, prime walk, exponent counts, factorial sum and running minimum
module fpd_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  fpd_pkg::fpd_cmd_type         cmd,
   output fpd_pkg::fpd_status_type      status,
   input  logic [fpd_pkg::VALUE_W-1:0]  n_value,
   input  logic [fpd_pkg::VALUE_W-1:0]  a_value,
   output logic [fpd_pkg::VALUE_W-1:0]  max_power
);
   import fpd_pkg::*;

   logic [VALUE_W-1:0]    n_ff, n_in;
   logic [VALUE_W-1:0]    a_ff, a_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [VALUE_W-1:0]    p_ff, p_in;
   logic [EXP_W-1:0]      e_ff, e_in;
   logic [VALUE_W-1:0]    sum_ff, sum_in;
   logic [VALUE_W-1:0]    best_ff, best_in;

   logic [VALUE_W-1:0]    rom_prime;
   logic [2*VALUE_W-1:0]  prime_sq;
   logic [VALUE_W-1:0]    pick_prime;
   logic [VALUE_W-1:0]    sum_new;
   logic                  div_start;
   logic [VALUE_W-1:0]    div_dvd;
   logic [VALUE_W-1:0]    div_dsr;
   logic                  div_done;
   logic [VALUE_W-1:0]    div_quot;
   logic [VALUE_W-1:0]    div_rem;

   // prime choice: once p*p exceeds the base, what is left is itself prime
   always_comb begin
      rom_prime  = PRIME_ROM[idx_ff];
      prime_sq   = rom_prime * rom_prime;
      pick_prime = (prime_sq > {{VALUE_W{1'b0}}, a_ff}) ? a_ff : rom_prime;
      sum_new    = sum_ff + div_quot;
   end

   // divider operand selection
   always_comb begin
      div_start = cmd.pick | cmd.strip | cmd.leg_init | cmd.leg_step;
      if (cmd.pick) begin
         div_dvd = a_ff;
         div_dsr = pick_prime;
      end else if (cmd.strip) begin
         div_dvd = div_quot;
         div_dsr = p_ff;
      end else if (cmd.leg_init) begin
         div_dvd = n_ff;
         div_dsr = p_ff;
      end else if (cmd.leg_step && (div_quot != '0)) begin
         div_dvd = div_quot;
         div_dsr = p_ff;
      end else begin
         div_dvd = sum_new;
         div_dsr = VALUE_W'(e_ff);
      end
   end

   fpd_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dvd),
      .divisor   (div_dsr),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   // next values of the working registers
   always_comb begin
      n_in    = n_ff;
      a_in    = a_ff;
      idx_in  = idx_ff;
      p_in    = p_ff;
      e_in    = e_ff;
      sum_in  = sum_ff;
      best_in = best_ff;
      if (cmd.load) begin
         n_in    = n_value;
         a_in    = a_value;
         idx_in  = '0;
         best_in = (a_value == '0) ? '0 : NO_BOUND;
      end
      if (cmd.pick) begin
         p_in = pick_prime;
         e_in = '0;
      end
      if (cmd.strip) begin
         a_in = div_quot;
         e_in = e_ff + EXP_W'(1);
      end
      if (cmd.skip || cmd.fold) begin
         idx_in = idx_ff + IDX_W'(1);
      end
      if (cmd.leg_init) begin
         sum_in = '0;
      end
      if (cmd.leg_step) begin
         sum_in = sum_new;
      end
      if (cmd.fold && (div_quot < best_ff)) begin
         best_in = div_quot;
      end
   end

   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      a_ff    <= a_in;
      idx_ff  <= idx_in;
      p_ff    <= p_in;
      e_ff    <= e_in;
      sum_ff  <= sum_in;
      best_ff <= best_in;
   end

   // status back to the controller
   always_comb begin
      status.a_done    = (a_ff[VALUE_W-1:1] == '0);
      status.div_done  = div_done;
      status.rem_zero  = (div_rem == '0);
      status.e_zero    = (e_ff == '0);
      status.quot_zero = (div_quot == '0);
   end

   assign max_power = best_ff;

endmodule

[rtl/core/fpd_ctrl.sv]
// controller state machine sequencing the prime walk and the divider
module fpd_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  fpd_pkg::fpd_status_type  status,
   output fpd_pkg::fpd_cmd_type     cmd
);
   import fpd_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SELECT = 6'b000010,
      ST_DIV_A  = 6'b000100,
      ST_LEG    = 6'b001000,
      ST_QDIV   = 6'b010000,
      ST_DONE   = 6'b100000
   } fpd_state_type;

   fpd_state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SELECT;
            end
         end
         ST_SELECT: begin
            if (status.a_done) begin
               state_in = ST_DONE;
            end else begin
               cmd.pick = 1'b1;
               state_in = ST_DIV_A;
            end
         end
         ST_DIV_A: begin
            if (status.div_done) begin
               if (status.rem_zero) begin
                  cmd.strip = 1'b1;
               end else if (status.e_zero) begin
                  cmd.skip = 1'b1;
                  state_in = ST_SELECT;
               end else begin
                  cmd.leg_init = 1'b1;
                  state_in     = ST_LEG;
               end
            end
         end
         ST_LEG: begin
            if (status.div_done) begin
               cmd.leg_step = 1'b1;
               if (status.quot_zero) begin
                  state_in = ST_QDIV;
               end
            end
         end
         ST_QDIV: begin
            if (status.div_done) begin
               cmd.fold = 1'b1;
               state_in = ST_SELECT;
            end
         end
         ST_DONE: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);

endmodule

[rtl/core/factorial_power_divisibility_top.sv]
// top level: largest power of a dividing n factorial, by Legendre's formula
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  req_n_value, req_a_value
//   rsp      out        rsp_valid/rsp_ready  rsp_max_power
//
// One transaction at a time; a new one is taken once the result has left.
// Every step runs through one shared divider: each trial prime up to the
// square root of the base costs one division per power found plus one, and
// each prime factor adds about log_p(n) divisions for the factorial sum and
// one for the exponent ratio.
// Synchronous active-high reset returns to idle; the prime table is constant.
// A stalled result is held in the output register until rsp_ready.
module factorial_power_divisibility_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [fpd_pkg::VALUE_W-1:0]  req_n_value,
   input  logic [fpd_pkg::VALUE_W-1:0]  req_a_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [fpd_pkg::VALUE_W-1:0]  rsp_max_power
);
   import fpd_pkg::*;

   fpd_cmd_type    cmd;
   fpd_status_type status;

   // sequencer
   fpd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic and working registers
   fpd_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .n_value   (req_n_value),
      .a_value   (req_a_value),
      .max_power (rsp_max_power)
   );

`ifndef SYNTH
   // at most one command per cycle
   assert property (@(posedge clock) disable iff (reset) $onehot0(cmd))
      else $error("more than one datapath command in a cycle");

   // a waiting result blocks new transactions
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !req_ready)
      else $error("input ready while a result is pending");

   // a result never appears the cycle right after an accepted transaction
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !rsp_valid)
      else $error("result presented without any processing");

   // the divider only reports done while a division step is expected
   assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> !req_ready && !rsp_valid)
      else $error("divider finished outside the prime walk");
`endif

endmodule

[verif/fpd_valuation_checker.sv]
// checker for the factorial power divisibility block: predicts each max_power and compares
module fpd_valuation_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic [fpd_pkg::VALUE_W-1:0]  req_n_value,
   input  logic [fpd_pkg::VALUE_W-1:0]  req_a_value,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [fpd_pkg::VALUE_W-1:0]  rsp_max_power,
   output int                           mismatch_count,
   output int                           pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import fpd_pkg::*;

   // one query in flight, with the power it must produce
   typedef struct {
      logic [VALUE_W-1:0] n_value;
      logic [VALUE_W-1:0] a_value;
      logic [VALUE_W-1:0] max_power;
   } valuation_type;

   valuation_type expected_powers[$];
   int errors = 0;

   // largest k with a^k dividing n!, minimum over the prime factors of a
   function automatic logic [VALUE_W-1:0] factorial_valuation(
      input logic [VALUE_W-1:0] n, input logic [VALUE_W-1:0] a);
      int unsigned rest;
      int unsigned best;
      int unsigned p;
      int unsigned e;
      int unsigned sum;
      int unsigned t;
      if (a == '0) begin
         return '0;
      end
      rest = a;
      best = NO_BOUND;
      // trial division: a composite divisor never divides once its
      // smaller prime factors have been stripped
      for (p = 2; p < (1 << VALUE_W) && rest > 1; p++) begin
         e = 0;
         while (rest % p == 0) begin
            rest = rest / p;
            e++;
         end
         if (e != 0) begin
            // exponent of p in n! as n/p + n/p^2 + ...
            sum = 0;
            t = n;
            while (t != 0) begin
               t = t / p;
               sum += t;
            end
            if (sum / e < best) begin
               best = sum / e;
            end
         end
      end
      return best[VALUE_W-1:0];
   endfunction

   // watch both channels at each edge, values seen are the ones accepted
   always @(posedge clock) begin
      valuation_type query;
      valuation_type head;
      if (!reset) begin
         // request transaction: predict and queue
         if (req_valid && req_ready) begin
            query.n_value = req_n_value;
            query.a_value = req_a_value;
            query.max_power = factorial_valuation(req_n_value, req_a_value);
            expected_powers.push_back(query);
         end
         // response transaction: compare with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (expected_powers.size() == 0) begin
               errors++;
               $display("%0t: unexpected result, expected none, actual max_power %0d",
                        $time, rsp_max_power);
            end else begin
               head = expected_powers.pop_front();
               if (rsp_max_power !== head.max_power) begin
                  errors++;
                  $display("%0t: n=%0d a=%0d expected max_power %0d, actual %0d",
                           $time, head.n_value, head.a_value, head.max_power,
                           rsp_max_power);
               end
            end
         end
      end
      mismatch_count <= errors;
      pending_count <= expected_powers.size();
   end

endmodule

[verif/factorial_power_divisibility_top_tb.sv]
// testbench top: clock, reset, request and response pacing, watchdog and verdict
module factorial_power_divisibility_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import fpd_pkg::*;

   localparam int RANDOM_QUERIES = 580;
   localparam int QUIET_LIMIT    = 20000;
   localparam int DRAIN_CYCLES   = 800;
   localparam int CORNER_COUNT   = 24;

   // corner pairs: n and a at zero, one, the field top, large primes
   localparam int unsigned CORNER_N [CORNER_COUNT] = '{
      0, 1, 1, 2, 1000, 5, 1023, 1023, 1000, 1023, 2, 1000,
      1023, 1020, 1021, 1009, 1018, 1000, 10, 6, 100, 1023, 0, 682
   };
   localparam int unsigned CORNER_A [CORNER_COUNT] = '{
      2, 2, 1000, 0, 0, 1, 1, 2, 2, 1023, 1023, 1000,
      1021, 1021, 1021, 1009, 1018, 512, 4, 6, 997, 1019, 0, 1
   };

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [VALUE_W-1:0]  req_n_value = '0;
   logic [VALUE_W-1:0]  req_a_value = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [VALUE_W-1:0]  rsp_max_power;

   int mismatch_count;
   int pending_count;
   int quiet_cycles = 0;
   bit pacing_on = 1'b1;

   factorial_power_divisibility_top uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_n_value   (req_n_value),
      .req_a_value   (req_a_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_max_power (rsp_max_power)
   );

   fpd_valuation_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_n_value    (req_n_value),
      .req_a_value    (req_a_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_max_power  (rsp_max_power),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // 4 ns clock
   initial begin
      forever #2 clock = ~clock;
   end

   // watchdog: too long with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("factorial_power_divisibility_top_tb failed");
            $finish;
         end
      end
   end

   // present one query, optionally after a gap, and hold it until taken
   task automatic push_query(input int unsigned n, input int unsigned a);
      int gap;
      gap = pacing_on ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_n_value <= n[VALUE_W-1:0];
      req_a_value <= a[VALUE_W-1:0];
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
   endtask

   // base: prime powers, products of small primes, table primes up to the largest, noise
   function automatic int unsigned pick_base();
      int unsigned v;
      int unsigned p;
      v = 1;
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 1023);
         1: begin
            p = PRIME_ROM[$urandom_range(0, 5)];
            v = p;
            while (v * p <= 1023 && $urandom_range(0, 3) != 0) v = v * p;
            return v;
         end
         2, 3: begin
            repeat (4) begin
               p = PRIME_ROM[$urandom_range(0, 14)];
               if (v * p <= 1023) v = v * p;
            end
            return (v < 2) ? 2 : v;
         end
         4: return PRIME_ROM[$urandom_range(0, PRIME_COUNT - 1)];
         5: return PRIME_ROM[$urandom_range(PRIME_COUNT - 4, PRIME_COUNT - 1)];
         default: return $urandom_range(2, 1000);
      endcase
   endfunction

   // n: mostly the whole field, some tiny and some near the top
   function automatic int unsigned pick_count();
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 1);
         1: return $urandom_range(0, 30);
         2: return $urandom_range(1000, 1023);
         default: return $urandom_range(2, 1023);
      endcase
   endfunction

   // response side: stall for a drawn number of cycles once a result shows
   initial begin
      int hold;
      wait (reset == 1'b0);
      forever begin
         hold = pacing_on ? $urandom_range(0, 5) : 0;
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            do @(negedge clock); while (!rsp_valid);
            repeat (hold) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(negedge clock); while (!rsp_valid);
         @(posedge clock);
      end
   end

   // reset, directed corners, random queries, drain and verdict
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < CORNER_COUNT; i++) begin
         push_query(CORNER_N[i], CORNER_A[i]);
      end

      for (int i = 0; i < RANDOM_QUERIES; i++) begin
         // switch between paced and back-to-back stretches
         if (i % 40 == 0) pacing_on = ($urandom_range(0, 3) != 0);
         push_query(pick_count(), pick_base());
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (pending_count != 0) begin
         $display("%0t: %0d results never arrived", $time, pending_count);
      end
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("factorial_power_divisibility_top_tb passed");
      end else begin
         $display("factorial_power_divisibility_top_tb failed");
      end
      $finish;
   end

endmodule
